// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// clocked concurrent assertions with and without a reset guard
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// checked at every rising edge, masked while reset is high
`define ASSERT_RST(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// checked at every rising edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");
`else
`define ASSERT_RST(lbl, clk, rst, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== rtl/sgr_pkg.sv =====
// ----------------------------------------------------------------------------
// sgr_pkg
// shared constants, types and the 5x7 font table of the glyph rasterizer
// ----------------------------------------------------------------------------
package sgr_pkg;

  localparam int MAX_SCALE = 3;
  localparam int SCALE_W   = $clog2(MAX_SCALE + 1);

  localparam int CELL_W     = 6;
  localparam int CELL_H     = 8;
  localparam int NUM_COLS   = 5;
  localparam int ROW_W      = $clog2(CELL_H);
  localparam int NUM_GLYPHS = 95;
  localparam int GLYPH_IDX_W = $clog2(NUM_GLYPHS);

  localparam logic [7:0] FIRST_CODE    = 8'd32;
  localparam logic [7:0] LAST_CODE     = 8'd126;
  localparam logic [7:0] FALLBACK_CODE = 8'd63;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 2'd2;

  localparam logic [15:0] FG_RESET    = 16'hFFFF;
  localparam logic [15:0] BG_RESET    = 16'h0000;
  localparam logic [1:0]  SCALE_RESET = 2'd1;

  // result kinds
  localparam logic KIND_WINDOW = 1'b0;
  localparam logic KIND_ROW    = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] win_x0;
    logic [15:0] win_y0;
    logic [15:0] win_x1;
    logic [15:0] win_y1;
    logic [15:0] col0_color;
    logic [15:0] col1_color;
    logic [15:0] col2_color;
    logic [15:0] col3_color;
    logic [15:0] col4_color;
    logic [15:0] col5_color;
    logic        last;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic             load_in;
    logic             load_win;
    logic             load_row;
    logic [ROW_W-1:0] row_idx;
    logic             last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic               slot_free;
    logic [SCALE_W-1:0] eff_scale;
  } status_t;

  // column bytes c0..c4, c0 in the top byte; glyph row r is bit r of each byte
  localparam logic [39:0] GLYPH_ROM [NUM_GLYPHS] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
    40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h081454543C,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
    40'h00007F0000, 40'h0041360800, 40'h08082A1C08
  };

endpackage

// ===== rtl/sgr_in_if.sv =====
// ----------------------------------------------------------------------------
// sgr_in_if
// character request channel: code and cell position
// ----------------------------------------------------------------------------
interface sgr_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  char_code;
  logic [15:0] pos_x;
  logic [15:0] pos_y;

  modport source (output valid, char_code, pos_x, pos_y, input ready);
  modport sink   (input valid, char_code, pos_x, pos_y, output ready);
endinterface

// ===== rtl/sgr_out_if.sv =====
// ----------------------------------------------------------------------------
// sgr_out_if
// result channel: address window and pixel row requests
// ----------------------------------------------------------------------------
interface sgr_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] win_x0;
  logic [15:0] win_y0;
  logic [15:0] win_x1;
  logic [15:0] win_y1;
  logic [15:0] col0_color;
  logic [15:0] col1_color;
  logic [15:0] col2_color;
  logic [15:0] col3_color;
  logic [15:0] col4_color;
  logic [15:0] col5_color;
  logic        last;

  modport source (
    output valid, kind, win_x0, win_y0, win_x1, win_y1,
           col0_color, col1_color, col2_color, col3_color, col4_color, col5_color, last,
    input  ready
  );
  modport sink (
    input  valid, kind, win_x0, win_y0, win_x1, win_y1,
           col0_color, col1_color, col2_color, col3_color, col4_color, col5_color, last,
    output ready
  );
endinterface

// ===== rtl/sgr_cfg_if.sv =====
// ----------------------------------------------------------------------------
// sgr_cfg_if
// configuration write channel: register index and data
// ----------------------------------------------------------------------------
interface sgr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/sgr_ctrl.sv =====
// ----------------------------------------------------------------------------
// sgr_ctrl
// sequencer: takes a character, issues the window, then scale commands per glyph row
// ----------------------------------------------------------------------------
module sgr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sgr_pkg::status_t status,
  output sgr_pkg::cmd_t    cmd
);
  import sgr_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_WIN, S_ROW} state_t;

  state_t             state;
  logic [ROW_W-1:0]   row;
  logic [SCALE_W-1:0] rep;
  logic               rep_end;
  logic               row_end;

  assign rep_end = (rep == status.eff_scale - SCALE_W'(1));
  assign row_end = (row == ROW_W'(CELL_H - 1));

  always_comb begin
    in_ready     = (state == S_IDLE);
    cmd.load_in  = (state == S_IDLE) && in_valid;
    cmd.load_win = (state == S_WIN) && status.slot_free;
    cmd.load_row = (state == S_ROW) && status.slot_free;
    cmd.row_idx  = row;
    cmd.last     = rep_end && row_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      row   <= '0;
      rep   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_WIN;
        end
        S_WIN: begin
          if (status.slot_free) begin
            state <= S_ROW;
            row   <= '0;
            rep   <= '0;
          end
        end
        S_ROW: begin
          if (status.slot_free) begin
            if (rep_end) begin
              rep <= '0;
              if (row_end) state <= S_IDLE;
              else row <= row + ROW_W'(1);
            end else begin
              rep <= rep + SCALE_W'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/sgr_datapath.sv =====
// ----------------------------------------------------------------------------
// sgr_datapath
// config registers, character capture, font lookup and the output register
// ----------------------------------------------------------------------------
module sgr_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic [sgr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [15:0]                       cfg_data,
  input  logic [7:0]                        char_code,
  input  logic [15:0]                       pos_x,
  input  logic [15:0]                       pos_y,
  input  sgr_pkg::cmd_t                     cmd,
  output sgr_pkg::status_t                  status,
  output logic                              out_valid,
  input  logic                              out_ready,
  output sgr_pkg::result_t                  result
);
  import sgr_pkg::*;

  logic [15:0]            fg_color;
  logic [15:0]            bg_color;
  logic [1:0]             scale;
  logic [SCALE_W-1:0]     eff_scale;
  logic [SCALE_W-1:0]     eff_scale_next;
  logic [GLYPH_IDX_W-1:0] glyph_idx;
  logic [39:0]            glyph;
  logic [15:0]            x0;
  logic [15:0]            y0;
  logic [15:0]            span_x;
  logic [15:0]            span_y;
  logic [15:0]            row_color [NUM_COLS];
  logic [7:0]             col_byte;
  result_t                result_next;

  // config writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color <= FG_RESET;
      bg_color <= BG_RESET;
      scale    <= SCALE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FG_COLOR: fg_color <= cfg_data;
        CFG_BG_COLOR: bg_color <= cfg_data;
        CFG_SCALE:    scale    <= cfg_data[1:0];
        default:      ;
      endcase
    end
  end

  // zero scale acts as one, large scales saturate
  always_comb begin
    if (scale == 2'd0)                    eff_scale_next = SCALE_W'(1);
    else if (32'(scale) > MAX_SCALE)      eff_scale_next = SCALE_W'(MAX_SCALE);
    else                                  eff_scale_next = SCALE_W'(scale);
  end

  // out of range codes fall back to question mark
  always_comb begin
    if (char_code < FIRST_CODE || char_code > LAST_CODE)
      glyph_idx = GLYPH_IDX_W'(FALLBACK_CODE - FIRST_CODE);
    else
      glyph_idx = GLYPH_IDX_W'(char_code - FIRST_CODE);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x0        <= pos_x;
      y0        <= pos_y;
      glyph     <= GLYPH_ROM[glyph_idx];
      eff_scale <= eff_scale_next;
    end
  end

  assign span_x = 16'(eff_scale) * 16'(CELL_W);
  assign span_y = 16'(eff_scale) * 16'(CELL_H);

  always_comb begin
    col_byte = '0;
    for (int c = 0; c < NUM_COLS; c++) begin
      col_byte     = glyph[39 - 8*c -: 8];
      row_color[c] = col_byte[cmd.row_idx] ? fg_color : bg_color;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_win || cmd.load_row) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    result_next = '0;
    if (cmd.load_win) begin
      result_next.kind   = KIND_WINDOW;
      result_next.win_x0 = x0;
      result_next.win_y0 = y0;
      result_next.win_x1 = x0 + span_x - 16'd1;
      result_next.win_y1 = y0 + span_y - 16'd1;
    end else begin
      result_next.kind       = KIND_ROW;
      result_next.col0_color = row_color[0];
      result_next.col1_color = row_color[1];
      result_next.col2_color = row_color[2];
      result_next.col3_color = row_color[3];
      result_next.col4_color = row_color[4];
      result_next.col5_color = bg_color;
      result_next.last       = cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_win || cmd.load_row) begin
      result <= result_next;
    end
  end

  assign status.slot_free = !out_valid || out_ready;
  assign status.eff_scale = eff_scale;
endmodule

// ===== rtl/scaled_glyph_rasterizer.sv =====
// ----------------------------------------------------------------------------
// scaled_glyph_rasterizer
// 5x7 font character generator with integer magnification
// ----------------------------------------------------------------------------
//
//   channel  dir  moves                                   accepted when
//   -------  ---  --------------------------------------  -----------------
//   din      in   char_code, pos_x, pos_y                 valid && ready
//   dout     out  window or pixel row request, last flag  valid && ready
//   cfg      in   index, data (fg_color, bg_color, scale) valid && ready
//
// a character is handled in order: the sequencer takes the request, then
// issues the window request, then 8*scale row requests; the single output
// register moves one request per cycle while dout.ready is high.
// reset is synchronous and active high; it clears the sequencer, the output
// valid flag and puts the registers at fg 0xffff, bg 0, scale 1.
// a low dout.ready holds the output register and stalls the sequencer; the
// next character may be taken while the last row request still waits.
// ----------------------------------------------------------------------------
module scaled_glyph_rasterizer (
  input  logic       clk,
  input  logic       rst,
  sgr_in_if.sink     din,
  sgr_out_if.source  dout,
  sgr_cfg_if.sink    cfg
);
  import sgr_pkg::*;

  `include "assert_macros.svh"

  cmd_t    cmd;
  status_t status;
  result_t result;
  logic    out_valid;

  // config writes are always taken
  assign cfg.ready = 1'b1;

  // sequencer: idle -> window -> rows
  sgr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .in_ready (din.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // registers, font lookup, window math and the output register
  sgr_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .char_code (din.char_code),
    .pos_x     (din.pos_x),
    .pos_y     (din.pos_y),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (dout.ready),
    .result    (result)
  );

  // result struct onto the channel
  assign dout.valid      = out_valid;
  assign dout.kind       = result.kind;
  assign dout.win_x0     = result.win_x0;
  assign dout.win_y0     = result.win_y0;
  assign dout.win_x1     = result.win_x1;
  assign dout.win_y1     = result.win_y1;
  assign dout.col0_color = result.col0_color;
  assign dout.col1_color = result.col1_color;
  assign dout.col2_color = result.col2_color;
  assign dout.col3_color = result.col3_color;
  assign dout.col4_color = result.col4_color;
  assign dout.col5_color = result.col5_color;
  assign dout.last       = result.last;

  // a taken character moves the sequencer out of idle
  `ASSERT_RST(a_busy_after_take, clk, rst, (din.valid && din.ready) |=> !din.ready)
  // while a window request is shown the rows are still to come
  `ASSERT_RST(a_win_blocks_input, clk, rst, (dout.valid && dout.kind == KIND_WINDOW) |-> !din.ready)
  // a window request never closes the character
  `ASSERT_RST(a_win_not_last, clk, rst, (dout.valid && dout.kind == KIND_WINDOW) |-> !dout.last)
  // sequencer only loads into a free output slot
  `ASSERT_RST(a_load_free, clk, rst, (cmd.load_win || cmd.load_row) |-> status.slot_free)
endmodule
